// ===== src/fud_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fud_pkg: shared types and constants of the form body decoder
// Defines the item classes, result kinds, escape steps and register map
// that the front, queue and back modules share.
// ----------------------------------------------------------------------------
package fud_pkg;

	// Default parameter values.
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Register reset values.
	localparam logic [15:0] RST_MAX_NAME  = 16'd1023;
	localparam logic [15:0] RST_MAX_VALUE = 16'd4095;

	// Special characters of the encoding.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	// Register index, taken from paddr[2].
	typedef enum logic {
		REG_MAX_NAME  = 1'b0,
		REG_MAX_VALUE = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		K_NAME  = 3'd0,
		K_VALUE = 3'd1,
		K_PAIR  = 3'd2,
		K_DONE  = 3'd3,
		K_ERROR = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		CL_BYTE = 3'd0,
		CL_PCT  = 3'd1,
		CL_PLUS = 3'd2,
		CL_EQ   = 3'd3,
		CL_AMP  = 3'd4
	} cls_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_HIGH = 2'd1,
		ESC_LOW  = 2'd2
	} esc_t;

	// One classified item as it travels through the queue.
	typedef struct packed {
		logic       is_end;
		cls_t       cls;
		logic       hex_ok;
		logic [3:0] hex_val;
		logic [7:0] raw;
	} item_t;

endpackage
`default_nettype wire

// ===== src/fud_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fud_front: input acceptance and classification
// Takes a raw body byte, folds the zero byte into the end marker, and
// decodes the character class and hex digit value for the back end.
// ----------------------------------------------------------------------------
module fud_front import fud_pkg::*; (
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       is_end,
	input  logic       q_full,
	output logic       in_stall,
	output logic       push,
	output item_t      item
);

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		item.raw     = in_byte;
		item.is_end  = is_end || (in_byte == CH_NUL);
		item.hex_ok  = 1'b0;
		item.hex_val = in_byte[3:0];
		if (in_byte inside {[8'h30:8'h39]}) begin
			item.hex_ok = 1'b1;
		end else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			// The low nibble of 'A'..'F' and 'a'..'f' runs from 1 to 6.
			item.hex_ok  = 1'b1;
			item.hex_val = in_byte[3:0] + 4'd9;
		end
		case (in_byte)
			CH_PCT:  item.cls = CL_PCT;
			CH_PLUS: item.cls = CL_PLUS;
			CH_EQ:   item.cls = CL_EQ;
			CH_AMP:  item.cls = CL_AMP;
			default: item.cls = CL_BYTE;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/fud_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fud_queue: short queue of classified items
// A small register FIFO that lets the front and the back stall apart.
// ----------------------------------------------------------------------------
module fud_queue import fud_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	input  logic  pop,
	output logic  full,
	output logic  head_valid,
	output item_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t         entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   cnt_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (cnt_q == (AW+1)'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/fud_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fud_back: form state and result register
// Carries out one classified item per cycle against the form state, unless
// a stalled output register holds it, and loads its result into that register;
// an end marker that closes a value yields a pair mark and then a done mark.
// ----------------------------------------------------------------------------
module fud_back import fud_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] max_name,
	input  logic [15:0] max_value,
	input  logic        hv,
	input  item_t       h,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  out_byte,
	output logic [15:0] pair_count,
	output logic        run_last
);

	localparam int PC_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;

	// Form state.
	logic            in_value_q;
	esc_t            esc_q;
	logic [3:0]      high_q;
	logic [15:0]     len_q;
	logic [PC_W-1:0] pairs_q;
	logic            seen_q;
	logic            failed_q;
	logic            pend_q;

	// Output register.
	logic            out_valid_q;
	kind_t           out_kind_q;
	logic [7:0]      out_byte_q;
	logic [15:0]     out_cnt_q;
	logic            out_last_q;

	// Next state.
	logic            in_value_d;
	esc_t            esc_d;
	logic [3:0]      high_d;
	logic [15:0]     len_d;
	logic [PC_W-1:0] pairs_d;
	logic            seen_d;
	logic            failed_d;

	// Result of the head item.
	logic            res_has;
	kind_t           res_kind;
	logic            res_bump;
	logic            res_last;
	logic            res_two;

	logic            is_data;
	logic [7:0]      dec_byte;
	logic [15:0]     lim;
	logic            emit_ok;
	logic [PC_W-1:0] pairs_inc;
	logic            slot_free;
	logic            fire;

	assign pairs_inc = (pairs_q == '1) ? pairs_q : pairs_q + 1'b1;
	assign lim       = in_value_q ? max_value : max_name;

	// The decoded byte: a finished escape, a plus sign, or the raw byte.
	always_comb begin
		if (esc_q == ESC_LOW) begin
			dec_byte = {high_q, h.hex_val};
		end else if (h.cls == CL_PLUS) begin
			dec_byte = CH_SPACE;
		end else begin
			dec_byte = h.raw;
		end
	end

	// Is the head a byte that goes to the current field?
	always_comb begin
		is_data = 1'b0;
		if (!failed_q && !h.is_end) begin
			if (esc_q != ESC_NONE) begin
				is_data = h.hex_ok && (esc_q == ESC_LOW);
			end else begin
				case (h.cls)
					CL_PCT:  is_data = 1'b0;
					CL_EQ:   is_data = in_value_q;
					CL_AMP:  is_data = !in_value_q;
					default: is_data = 1'b1;
				endcase
			end
		end
	end

	assign emit_ok = is_data && (dec_byte != CH_NUL) && (len_q < lim);

	// Result of the head item.
	always_comb begin
		res_has  = 1'b0;
		res_kind = in_value_q ? K_VALUE : K_NAME;
		res_bump = 1'b0;
		res_last = 1'b1;
		res_two  = 1'b0;
		if (failed_q) begin
			res_has = 1'b0;
		end else if (h.is_end) begin
			res_has = 1'b1;
			if (esc_q != ESC_NONE) begin
				res_kind = K_ERROR;
			end else if (in_value_q) begin
				res_bump = 1'b1;
				if (!pend_q) begin
					res_kind = K_PAIR;
					res_last = 1'b0;
					res_two  = 1'b1;
				end else begin
					res_kind = K_DONE;
				end
			end else if (seen_q) begin
				res_kind = K_ERROR;
			end else begin
				res_kind = K_DONE;
			end
		end else if (esc_q != ESC_NONE && !h.hex_ok) begin
			res_has  = 1'b1;
			res_kind = K_ERROR;
		end else if (esc_q == ESC_NONE && h.cls == CL_AMP && in_value_q) begin
			res_has  = 1'b1;
			res_kind = K_PAIR;
			res_bump = 1'b1;
		end else begin
			res_has = emit_ok;
		end
	end

	assign slot_free = !out_valid_q || !out_stall;
	assign fire      = hv && (!res_has || slot_free);
	assign pop       = fire && !res_two;

	// Next form state once the head item is retired.
	always_comb begin
		in_value_d = in_value_q;
		esc_d      = esc_q;
		high_d     = high_q;
		len_d      = len_q;
		pairs_d    = pairs_q;
		seen_d     = seen_q;
		failed_d   = failed_q;
		if (failed_q || h.is_end) begin
			if ((!failed_q && esc_q != ESC_NONE)
					|| (!failed_q && !in_value_q && seen_q)) begin
				failed_d = 1'b1;
			end else if (h.is_end) begin
				in_value_d = 1'b0;
				esc_d      = ESC_NONE;
				high_d     = '0;
				len_d      = '0;
				pairs_d    = '0;
				seen_d     = 1'b0;
				failed_d   = 1'b0;
			end
		end else begin
			seen_d = 1'b1;
			if (esc_q != ESC_NONE && !h.hex_ok) begin
				failed_d = 1'b1;
			end else if (esc_q == ESC_HIGH) begin
				high_d = h.hex_val;
				esc_d  = ESC_LOW;
			end else if (esc_q == ESC_NONE && h.cls == CL_PCT) begin
				esc_d = ESC_HIGH;
			end else if (esc_q == ESC_NONE && h.cls == CL_EQ && !in_value_q) begin
				in_value_d = 1'b1;
				len_d      = '0;
			end else if (esc_q == ESC_NONE && h.cls == CL_AMP && in_value_q) begin
				pairs_d    = pairs_inc;
				in_value_d = 1'b0;
				len_d      = '0;
			end else begin
				esc_d = ESC_NONE;
				if (emit_ok) begin
					len_d = len_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_value_q  <= 1'b0;
			esc_q       <= ESC_NONE;
			high_q      <= '0;
			len_q       <= '0;
			pairs_q     <= '0;
			seen_q      <= 1'b0;
			failed_q    <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				in_value_q <= in_value_d;
				esc_q      <= esc_d;
				high_q     <= high_d;
				len_q      <= len_d;
				pairs_q    <= pairs_d;
				seen_q     <= seen_d;
				failed_q   <= failed_d;
				pend_q     <= 1'b0;
			end else if (fire && res_two) begin
				pend_q <= 1'b1;
			end
			if (fire && res_has) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_has) begin
			out_kind_q <= res_kind;
			out_byte_q <= (res_kind == K_NAME || res_kind == K_VALUE) ? dec_byte : 8'h00;
			out_cnt_q  <= 16'(res_bump ? pairs_inc : pairs_q);
			out_last_q <= res_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = out_kind_q;
	assign out_byte   = out_byte_q;
	assign pair_count = out_cnt_q;
	assign run_last   = out_last_q;

`ifndef ASSERT_OFF
	// The second result is only owed while the closing end marker waits.
	a_pend_head: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> hv && h.is_end && in_value_q && !failed_q)
		else $error("pending second result without its end marker");

	// The first of two results is a pair mark that is not the last one.
	a_two_first: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_two |=> out_valid_q && out_kind_q == K_PAIR && !out_last_q)
		else $error("first of two results is not an open pair mark");

	// A form-level mark always closes the results of its item.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_kind_q == K_DONE || out_kind_q == K_ERROR) |-> out_last_q)
		else $error("form done or error not flagged as last");

	// While failed, no result is produced.
	a_failed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |-> !res_has)
		else $error("result produced while swallowing a failed form");
`endif

endmodule
`default_nettype wire

// ===== src/form_urlencoded_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// form_urlencoded_decoder: streaming decoder for form-encoded bodies
// Splits a body into name=value pairs and emits the decoded name and value
// bytes, a mark per completed pair and a final done or error mark.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload                              dir
//  -------   ------------------   ----------------------------------   ---
//  input     in_valid / in_stall  in_byte, is_end                      in
//  output    out_valid/out_stall  kind, out_byte, pair_count, run_last out
//  config    APB psel/penable     paddr, pwdata, prdata, pready        in
//
// The block takes one item per cycle while in_stall is low. An accepted item
// is written into the classification queue, and from the head of the queue
// the state logic carries it into the output register, where its first
// result is offered. The only item that holds the state logic longer is an
// end marker that closes a value, because it yields a pair mark and then a
// done mark.
// Reset is asynchronous and active low; it clears the form state, the queue
// and the output valid flag, and loads the two length limits with their
// defaults. A stall on the output holds the result register; the queue then
// absorbs up to QUEUE_DEPTH items before in_stall is raised.
//
// Register map (32-bit data, only the low 16 bits are kept):
//   0x0  max_name_bytes   most decoded bytes kept per name
//   0x4  max_value_bytes  most decoded bytes kept per value
// The register is selected by paddr[2]; the byte-offset bits are ignored.
// ----------------------------------------------------------------------------
module form_urlencoded_decoder import fud_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// Input item channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        is_end,

	// Result item channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  out_byte,
	output logic [15:0] pair_count,
	output logic        run_last,

	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] max_name_q;
	logic [15:0] max_value_q;
	reg_idx_t    reg_sel;
	logic        cfg_wr;

	logic        q_full;
	logic        push;
	item_t       wr_item;
	logic        pop;
	logic        head_valid;
	item_t       head;

	// Configuration registers. The user writes them only while the block is idle
	// (unchecked by the block); the back end reads the limits straight from them.
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_q  <= RST_MAX_NAME;
			max_value_q <= RST_MAX_VALUE;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_MAX_NAME:  max_name_q  <= pwdata[15:0];
				REG_MAX_VALUE: max_value_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MAX_NAME:  prdata = {16'h0000, max_name_q};
			REG_MAX_VALUE: prdata = {16'h0000, max_value_q};
			default:       prdata = '0;
		endcase
	end

	// Front end: accept and classify.
	fud_front u_front (
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.is_end   (is_end),
		.q_full   (q_full),
		.in_stall (in_stall),
		.push     (push),
		.item     (wr_item)
	);

	// Queue between the front and the back.
	fud_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_item    (wr_item),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back end: form state and result register.
	fud_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_name   (max_name_q),
		.max_value  (max_value_q),
		.hv         (head_valid),
		.h          (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.out_byte   (out_byte),
		.pair_count (pair_count),
		.run_last   (run_last)
	);

endmodule
`default_nettype wire
